// ===== design/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and the queue entry type shared by the quaternion rotate modules.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// field widths of the item
	localparam int VW = 16;
	localparam int QW = 16;

	// widest of the two field widths
	localparam int MW = (QW > VW) ? QW : VW;
	// first products, sums of up to four of them, second products, rotated numerator
	localparam int PW = QW + MW;
	localparam int SW = PW + 2;
	localparam int TW = SW + MW;
	localparam int RW = TW + 3;

	// queue between front and back
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	// numerator per axis, squared norm and zero flag of one item
	typedef struct packed {
		logic signed [RW-1:0] rx;
		logic signed [RW-1:0] ry;
		logic signed [RW-1:0] rz;
		logic [SW-1:0]        n;
		logic                 zq;
	} qvr_work_t;

endpackage

// ===== design/quaternion_vector_rotate_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a 16-bit vector by a Q2.14 quaternion, dividing by the squared norm.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid/in_ready carries quat_x/y/z/w and vec_x/y/z;
//   output channel out_valid/out_ready carries rot_x/y/z, saturated and
//   zero_quaternion. One result item per input item, in order.
// - from input acceptance to out_valid an item passes 3 multiply/add stages
//   and a queue write in the front, then a 16-stage one-bit-per-stage
//   divider and the output register.
// - throughput is one item per cycle while out_ready holds; the front
//   multipliers and the divider are fully pipelined.
// - in_ready depends only on a credit count of items held in the front and
//   the 8-entry queue, never on in_valid or out_ready.
// - when the receiver stalls, the back end holds; the front keeps filling
//   the queue until the credits run out, then in_ready drops.
// - reset clears all valid bits and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [qvr_pkg::QW-1:0]  quat_x,
	input  logic signed [qvr_pkg::QW-1:0]  quat_y,
	input  logic signed [qvr_pkg::QW-1:0]  quat_z,
	input  logic signed [qvr_pkg::QW-1:0]  quat_w,
	input  logic signed [qvr_pkg::VW-1:0]  vec_x,
	input  logic signed [qvr_pkg::VW-1:0]  vec_y,
	input  logic signed [qvr_pkg::VW-1:0]  vec_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [qvr_pkg::VW-1:0]  rot_x,
	output logic signed [qvr_pkg::VW-1:0]  rot_y,
	output logic signed [qvr_pkg::VW-1:0]  rot_z,
	output logic                           saturated,
	output logic                           zero_quaternion
);
	import qvr_pkg::*;

	logic            take;
	logic            push, pop, empty;
	qvr_work_t       push_data, rdata;
	logic [QCW-1:0]  credit_q;

	// credits cover items in the front stages plus the queue
	assign in_ready = credit_q < QCW'(QDEPTH);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + QCW'(take) - QCW'(pop);
		end
	end

	qvr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.quat_w    (quat_w),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.push      (push),
		.push_data (push_data)
	);

	qvr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	qvr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rdata           (rdata),
		.empty           (empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.rot_x           (rot_x),
		.rot_y           (rot_y),
		.rot_z           (rot_z),
		.saturated       (saturated),
		.zero_quaternion (zero_quaternion)
	);

endmodule

// ===== design/qvr_front.sv =====
// ----------------------------------------------------------------------------
// qvr_front
// Takes items, flags the zero quaternion and forms the rotated numerator
// R = (w^2 - u.u) v + 2 (u.v) u + 2 w (u x v) and the squared norm N.
// ----------------------------------------------------------------------------
module qvr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic signed [qvr_pkg::QW-1:0]  quat_x,
	input  logic signed [qvr_pkg::QW-1:0]  quat_y,
	input  logic signed [qvr_pkg::QW-1:0]  quat_z,
	input  logic signed [qvr_pkg::QW-1:0]  quat_w,
	input  logic signed [qvr_pkg::VW-1:0]  vec_x,
	input  logic signed [qvr_pkg::VW-1:0]  vec_y,
	input  logic signed [qvr_pkg::VW-1:0]  vec_z,
	output logic                           push,
	output qvr_pkg::qvr_work_t             push_data
);
	import qvr_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic zq_s1, zq_s2, zq_s3;

	logic signed [PW-1:0] pxx_s1, pyy_s1, pzz_s1, pww_s1;
	logic signed [PW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0] cxa_s1, cxb_s1, cya_s1, cyb_s1, cza_s1, czb_s1;
	logic signed [QW-1:0] ux_s1, uy_s1, uz_s1, w_s1;
	logic signed [VW-1:0] vx_s1, vy_s1, vz_s1;

	logic signed [SW-1:0] uu;
	logic signed [SW-1:0] n_s2, s_s2, d_s2, cx_s2, cy_s2, cz_s2;
	logic signed [QW-1:0] ux_s2, uy_s2, uz_s2, w_s2;
	logic signed [VW-1:0] vx_s2, vy_s2, vz_s2;

	logic signed [TW-1:0] tsx_s3, tsy_s3, tsz_s3;
	logic signed [TW-1:0] tdx_s3, tdy_s3, tdz_s3;
	logic signed [TW-1:0] twx_s3, twy_s3, twz_s3;
	logic signed [SW-1:0] n_s3;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// first products of components
	always_ff @(posedge clk) begin
		zq_s1  <= (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);
		pxx_s1 <= quat_x * quat_x;
		pyy_s1 <= quat_y * quat_y;
		pzz_s1 <= quat_z * quat_z;
		pww_s1 <= quat_w * quat_w;
		dx_s1  <= quat_x * vec_x;
		dy_s1  <= quat_y * vec_y;
		dz_s1  <= quat_z * vec_z;
		cxa_s1 <= quat_y * vec_z;
		cxb_s1 <= quat_z * vec_y;
		cya_s1 <= quat_z * vec_x;
		cyb_s1 <= quat_x * vec_z;
		cza_s1 <= quat_x * vec_y;
		czb_s1 <= quat_y * vec_x;
		ux_s1  <= quat_x;
		uy_s1  <= quat_y;
		uz_s1  <= quat_z;
		w_s1   <= quat_w;
		vx_s1  <= vec_x;
		vy_s1  <= vec_y;
		vz_s1  <= vec_z;
	end

	// norm, scalar weight, dot and cross products
	assign uu = SW'(pxx_s1) + SW'(pyy_s1) + SW'(pzz_s1);

	always_ff @(posedge clk) begin
		zq_s2 <= zq_s1;
		n_s2  <= SW'(pww_s1) + uu;
		s_s2  <= SW'(pww_s1) - uu;
		d_s2  <= SW'(dx_s1) + SW'(dy_s1) + SW'(dz_s1);
		cx_s2 <= SW'(cxa_s1) - SW'(cxb_s1);
		cy_s2 <= SW'(cya_s1) - SW'(cyb_s1);
		cz_s2 <= SW'(cza_s1) - SW'(czb_s1);
		ux_s2 <= ux_s1;
		uy_s2 <= uy_s1;
		uz_s2 <= uz_s1;
		w_s2  <= w_s1;
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		vz_s2 <= vz_s1;
	end

	// second products of the three terms per axis
	always_ff @(posedge clk) begin
		zq_s3  <= zq_s2;
		n_s3   <= n_s2;
		tsx_s3 <= s_s2 * vx_s2;
		tsy_s3 <= s_s2 * vy_s2;
		tsz_s3 <= s_s2 * vz_s2;
		tdx_s3 <= d_s2 * ux_s2;
		tdy_s3 <= d_s2 * uy_s2;
		tdz_s3 <= d_s2 * uz_s2;
		twx_s3 <= cx_s2 * w_s2;
		twy_s3 <= cy_s2 * w_s2;
		twz_s3 <= cz_s2 * w_s2;
	end

	// numerator sum goes straight into the queue
	assign push         = valid_s3;
	assign push_data.rx = RW'(tsx_s3) + (RW'(tdx_s3) <<< 1) + (RW'(twx_s3) <<< 1);
	assign push_data.ry = RW'(tsy_s3) + (RW'(tdy_s3) <<< 1) + (RW'(twy_s3) <<< 1);
	assign push_data.rz = RW'(tsz_s3) + (RW'(tdz_s3) <<< 1) + (RW'(twz_s3) <<< 1);
	assign push_data.n  = $unsigned(n_s3);
	assign push_data.zq = zq_s3;

endmodule

// ===== design/qvr_fifo.sv =====
// ----------------------------------------------------------------------------
// qvr_fifo
// Short queue of numerator items between the front and the divider back end.
// ----------------------------------------------------------------------------
module qvr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qvr_pkg::qvr_work_t  wdata,
	input  logic                pop,
	output qvr_pkg::qvr_work_t  rdata,
	output logic                empty
);
	import qvr_pkg::*;

	qvr_work_t        entry_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             full;

	assign full  = (count_q == QCW'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("item pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("item popped from empty queue");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill count");

endmodule

// ===== design/qvr_lane.sv =====
// ----------------------------------------------------------------------------
// qvr_lane
// One axis: divides the signed numerator by the norm one quotient bit per
// stage, then rounds half away from zero and saturates, or gives zero for a zero quaternion.
// ----------------------------------------------------------------------------
module qvr_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qvr_pkg::RW-1:0] r_in,
	input  logic [qvr_pkg::SW-1:0]        n_in,
	input  logic                          zq_fin,
	output logic signed [qvr_pkg::VW-1:0] rot,
	output logic                          sat
);
	import qvr_pkg::*;

	localparam logic [VW:0] MAXP = (VW+1)'(2 ** (VW - 1) - 1);

	logic              neg_s [VW+1];
	logic              ovf_s [VW+1];
	logic [SW-1:0]     n_s   [VW+1];
	logic [RW-1:0]     rem_s [VW+1];
	logic [VW-1:0]     quo_s [VW+1];
	logic [RW-1:0]     rem_nx [1:VW];
	logic [VW-1:0]     quo_nx [1:VW];

	logic [RW-1:0]     mag;
	logic              ovf0;
	logic              rnd;
	logic [VW:0]       qr, qneg;
	logic              over;
	logic signed [VW-1:0] rot_q;
	logic              sat_q;

	// sign split and quotient range check
	assign mag  = r_in[RW-1] ? $unsigned(-r_in) : $unsigned(r_in);
	assign ovf0 = {1'b0, mag} >= ((RW+1)'(n_in) << VW);

	// restoring steps, most significant quotient bit first
	for (genvar i = 1; i <= VW; i++) begin : g_step
		localparam int K = VW - i;
		logic [RW:0] shf, dif;
		logic        ge;
		assign shf       = (RW+1)'(n_s[i-1]) << K;
		assign ge        = {1'b0, rem_s[i-1]} >= shf;
		assign dif       = {1'b0, rem_s[i-1]} - shf;
		assign rem_nx[i] = ge ? dif[RW-1:0] : rem_s[i-1];
		assign quo_nx[i] = ge ? (quo_s[i-1] | (VW'(1) << K)) : quo_s[i-1];
	end

	// rounding and clamp
	assign rnd  = {rem_s[VW], 1'b0} >= (RW+1)'(n_s[VW]);
	assign qr   = (VW+1)'(quo_s[VW]) + (VW+1)'(rnd);
	assign qneg = (VW+1)'(0) - qr;
	assign over = ovf_s[VW] || (neg_s[VW] ? (qr > MAXP + (VW+1)'(1)) : (qr > MAXP));

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= r_in[RW-1];
			ovf_s[0] <= ovf0;
			n_s[0]   <= n_in;
			rem_s[0] <= mag;
			quo_s[0] <= '0;
			for (int i = 1; i <= VW; i++) begin
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
				n_s[i]   <= n_s[i-1];
				rem_s[i] <= rem_nx[i];
				quo_s[i] <= quo_nx[i];
			end
			if (zq_fin) begin
				rot_q <= '0;
				sat_q <= 1'b0;
			end else if (over) begin
				rot_q <= neg_s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
				sat_q <= 1'b1;
			end else begin
				rot_q <= neg_s[VW] ? $signed(qneg[VW-1:0]) : $signed(qr[VW-1:0]);
				sat_q <= 1'b0;
			end
		end
	end

	assign rot = rot_q;
	assign sat = sat_q;

endmodule

// ===== design/qvr_back.sv =====
// ----------------------------------------------------------------------------
// qvr_back
// Pulls items from the queue and runs the three axis dividers in lock step
// behind one enable; the last stage is the output register.
// ----------------------------------------------------------------------------
module qvr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qvr_pkg::qvr_work_t             rdata,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [qvr_pkg::VW-1:0]  rot_x,
	output logic signed [qvr_pkg::VW-1:0]  rot_y,
	output logic signed [qvr_pkg::VW-1:0]  rot_z,
	output logic                           saturated,
	output logic                           zero_quaternion
);
	import qvr_pkg::*;

	logic          adv;
	logic [VW+1:0] vld_q;
	logic [VW+1:0] zq_pipe_q;
	logic          sat_x, sat_y, sat_z;

	// whole back end moves unless the output item is stalled
	assign adv       = !vld_q[VW+1] || out_ready;
	assign pop       = adv && !empty;
	assign out_valid = vld_q[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[VW:0], pop};
		end
	end

	// zero flag rides alongside the divider stages
	always_ff @(posedge clk) begin
		if (adv) zq_pipe_q <= {zq_pipe_q[VW:0], rdata.zq};
	end

	qvr_lane u_lane_x (
		.clk    (clk),
		.en     (adv),
		.r_in   (rdata.rx),
		.n_in   (rdata.n),
		.zq_fin (zq_pipe_q[VW]),
		.rot    (rot_x),
		.sat    (sat_x)
	);

	qvr_lane u_lane_y (
		.clk    (clk),
		.en     (adv),
		.r_in   (rdata.ry),
		.n_in   (rdata.n),
		.zq_fin (zq_pipe_q[VW]),
		.rot    (rot_y),
		.sat    (sat_y)
	);

	qvr_lane u_lane_z (
		.clk    (clk),
		.en     (adv),
		.r_in   (rdata.rz),
		.n_in   (rdata.n),
		.zq_fin (zq_pipe_q[VW]),
		.rot    (rot_z),
		.sat    (sat_z)
	);

	assign saturated       = sat_x | sat_y | sat_z;
	assign zero_quaternion = zq_pipe_q[VW+1];

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks quaternion_vector_rotate_top against an exact rational predictor of
// q*v*q^-1 with round half away from zero and 16-bit saturation. Directed
// corner items are followed by random items; both sides idle at random, and
// the receiver stalls long enough to fill the block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	typedef struct {
		logic signed [VW-1:0] x, y, z;
		logic                 sat, zq;
	} rot_t;

	// predicts the rotation of each accepted item and checks results in order
	class rotate_scoreboard;
		rot_t pending[$];
		int   errors = 0;
		int   checked = 0;
		int   sat_seen = 0;
		int   zero_seen = 0;

		function automatic logic signed [VW-1:0] div_round(
				input logic signed [127:0] r, input logic signed [127:0] n,
				ref logic sat);
			logic signed [127:0] mag, q, rem;
			logic                neg;
			neg = r < 0;
			mag = neg ? -r : r;
			q = mag / n;
			rem = mag % n;
			if (2 * rem >= n)
				q = q + 1;
			if (neg)
				q = -q;
			if (q > 32767) begin
				q = 32767;
				sat = 1;
			end else if (q < -32768) begin
				q = -32768;
				sat = 1;
			end
			return q[VW-1:0];
		endfunction

		function void note_item(logic signed [QW-1:0] qx, qy, qz, qw,
				logic signed [VW-1:0] vx, vy, vz);
			logic signed [127:0] ux, uy, uz, w, x, y, z, uu, ww, n, s, d, cx, cy, cz;
			rot_t e;
			ux = qx; uy = qy; uz = qz; w = qw; x = vx; y = vy; z = vz;
			e.sat = 0;
			e.zq = 0;
			if (ux == 0 && uy == 0 && uz == 0 && w == 0) begin
				e.x = 0; e.y = 0; e.z = 0; e.zq = 1;
			end else begin
				uu = ux * ux + uy * uy + uz * uz;
				ww = w * w;
				n = ww + uu;
				s = ww - uu;
				d = ux * x + uy * y + uz * z;
				cx = uy * z - uz * y;
				cy = uz * x - ux * z;
				cz = ux * y - uy * x;
				e.x = div_round(s * x + 2 * d * ux + 2 * w * cx, n, e.sat);
				e.y = div_round(s * y + 2 * d * uy + 2 * w * cy, n, e.sat);
				e.z = div_round(s * z + 2 * d * uz + 2 * w * cz, n, e.sat);
			end
			pending.push_back(e);
		endfunction

		function void check_result(rot_t got);
			rot_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
				return;
			end
			e = pending.pop_front();
			checked++;
			sat_seen += got.sat;
			zero_seen += got.zq;
			if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.sat !== e.sat
					|| got.zq !== e.zq) begin
				errors++;
				if (errors <= 10)
					$display("mismatch item %0d: exp %0d %0d %0d s%0b z%0b got %0d %0d %0d s%0b z%0b",
						checked - 1, e.x, e.y, e.z, e.sat, e.zq,
						got.x, got.y, got.z, got.sat, got.zq);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [QW-1:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
	logic signed [VW-1:0] vec_x = 0, vec_y = 0, vec_z = 0;
	logic signed [VW-1:0] rot_x, rot_y, rot_z;
	logic saturated, zero_quaternion;

	rotate_scoreboard board = new();
	bit sending_done = 0;
	bit long_hold = 0;
	bit hold_done = 0;

	quaternion_vector_rotate_top DUT (.*);

	always #4 clk = ~clk;

	// pick a 16-bit value, favoring extremes now and then
	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h4000;
			4: return 16'hc000;
			5: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one item and wait for acceptance; valid stays up for a follow-on item
	task automatic send_item(logic [15:0] qx, qy, qz, qw, vx, vy, vz);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
		vec_x <= vx; vec_y <= vy; vec_z <= vz;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		board.note_item(qx, qy, qz, qw, vx, vy, vz);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		logic [15:0] dq[$];
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: zero quaternion, identity, extremes, half-turns, ties
		send_item(0, 0, 0, 0, 16'h7fff, 16'h8000, 123);
		send_item(0, 0, 0, 16'h4000, 16'h7fff, 16'h8000, 16'hffff);
		send_item(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(0, 0, 16'h4000, 0, 16'h8000, 16'h7fff, 5);
		send_item(16'h4000, 0, 0, 0, 1, 16'h8000, 16'h7fff);
		send_item(0, 16'h2d41, 0, 16'h2d41, 16'h7fff, 0, 16'h7fff);
		send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
		send_item(1, 1, 0, 0, 1, 0, 0);
		send_item(1, 0, 0, 1, 0, 1, 0);
		send_item(16'h7fff, 0, 0, 1, 16'h7fff, 16'h7fff, 16'h8000);
		send_item(1, 1, 1, 1, 16'h8000, 16'h7fff, 16'h8000);
		send_item(0, 16'h8000, 0, 0, 16'h8000, 16'h8000, 16'h8000);
		send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_item(3, 0, 0, 1, 1, 1, 1);
		// random, with a long receiver hold and a drain pause partway
		for (int i = 0; i < 2000; i++) begin
			if (i == 500)
				long_hold = 1;
			if (i == 1000) begin
				in_valid <= 0;
				wait (hold_done && board.pending.size() == 0);
				@(negedge clk);
			end
			send_item(pick_field(), pick_field(), pick_field(), pick_field(),
				pick_field(), pick_field(), pick_field());
		end
		in_valid <= 0;
		sending_done = 1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				out_ready <= 0;
				repeat (300) @(negedge clk);
				hold_done = 1;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			board.check_result('{rot_x, rot_y, rot_z, saturated, zero_quaternion});
		end
	end

	// end of run
	initial begin
		wait (sending_done && board.pending.size() == 0);
		repeat (60) @(posedge clk);
		$display("checked %0d rotations (%0d saturated, %0d zero quaternions)",
			board.checked, board.sat_seen, board.zero_seen);
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end
endmodule
